### hw/rtl/bsr_pkg.sv
`default_nettype none

package bsr_pkg;

  // Low-nibble line commands of a port write
  typedef enum logic [3:0] {
    NIB_RESET_OFF = 4'h8,
    NIB_RESET_ON  = 4'h9,
    NIB_DATA_LOW  = 4'hC,
    NIB_DATA_HIGH = 4'hD,
    NIB_CLK_LOW   = 4'hE,
    NIB_CLK_HIGH  = 4'hF
  } line_cmd_t;

  // Port access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BANK_ONE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BANK_TWO = 2'd1;

  localparam logic [7:0] BANK_ONE_RESET = 8'd155;
  localparam logic [7:0] BANK_TWO_RESET = 8'd252;

  // Serial command codes
  localparam int unsigned CMD_W = 9;
  localparam logic [CMD_W-1:0] CMD_VERSION  = 9'h0FE;
  localparam logic [CMD_W-1:0] CMD_BANK_ONE = 9'h082;
  localparam logic [CMD_W-1:0] CMD_BANK_TWO = 9'h086;
  localparam logic [7:0]       VERSION_BYTE = 8'hFF;

  // Shift position limits
  localparam logic [4:0] SHIFT_LIMIT = 5'd9;
  localparam logic [4:0] DECODE_POS  = 5'd8;
  localparam logic [4:0] REPLY_LIMIT = 5'd16;
  localparam logic [4:0] POS_MAX     = 5'd31;

  // Read data bit places
  localparam int unsigned READ_CLK_BIT   = 3;
  localparam int unsigned READ_REPLY_BIT = 1;

  typedef struct packed {
    logic       action;
    logic [7:0] write_value;
    logic [7:0] start_inputs;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       unknown_command;
  } rsp_t;

  typedef struct packed {
    logic [7:0] switch_bank_one;
    logic [7:0] switch_bank_two;
  } banks_t;

endpackage

`default_nettype wire

### hw/rtl/bitbang_serial_command_responder.sv
`default_nettype none

// A result beat is presented in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle; the line state updates in the accepting cycle.
// The single result register stalls the request side only while it is full and stalled.
// Reset (rst, synchronous, active high) clears all line state and the result valid flag,
// leaves the result payload as it was, and loads the switch banks with 155 and 252.
module bitbang_serial_command_responder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request channel
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire bsr_pkg::req_t                     req,
  // response channel
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output bsr_pkg::rsp_t                          rsp,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [bsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  bsr_pkg::banks_t banks;
  bsr_pkg::rsp_t   result;
  logic            fire;
  logic            rsp_valid_next;

  // Hold the request side only when the result register is full and not drained.
  assign req_stall = rsp_valid && rsp_stall;
  assign fire      = req_valid && !req_stall;

  bsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .banks     (banks)
  );

  // Line state, decode and the per-beat result
  bsr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .req    (req),
    .banks  (banks),
    .result (result)
  );

  // Advance the result register on an accepted beat, drop it once taken.
  always_comb begin
    if (fire) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_stall) begin
      rsp_valid_next = rsp_valid;
    end else begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload loads only with a new beat, so a stalled result holds.
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with an empty result register");

  a_beat_presented: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("accepted beat produced no result");

  a_result_taken_or_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !fire |=> !rsp_valid)
    else $error("result presented twice");
`endif

endmodule

`default_nettype wire

### hw/rtl/bsr_cfg.sv
`default_nettype none

module bsr_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [bsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [7:0]                        cfg_data,
  output bsr_pkg::banks_t                        banks
);

  bsr_pkg::banks_t banks_next;

  always_comb begin
    banks_next = banks;
    if (cfg_we) begin
      case (cfg_index)
        bsr_pkg::CFG_BANK_ONE: banks_next.switch_bank_one = cfg_data;
        bsr_pkg::CFG_BANK_TWO: banks_next.switch_bank_two = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      banks.switch_bank_one <= bsr_pkg::BANK_ONE_RESET;
      banks.switch_bank_two <= bsr_pkg::BANK_TWO_RESET;
    end else begin
      banks <= banks_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bsr_core.sv
`default_nettype none

module bsr_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire bsr_pkg::req_t    req,
  input  wire bsr_pkg::banks_t  banks,
  output bsr_pkg::rsp_t         result
);

  logic                        reset_held;
  logic [4:0]                  bit_position;
  logic [bsr_pkg::CMD_W-1:0]   command_shift;
  logic                        data_level;
  logic                        clock_level;
  logic                        reply_bit;
  logic [15:0]                 reply_word;

  logic                        reset_held_next;
  logic [4:0]                  bit_position_next;
  logic [bsr_pkg::CMD_W-1:0]   command_shift_next;
  logic                        data_level_next;
  logic                        clock_level_next;
  logic                        reply_bit_next;
  logic [15:0]                 reply_word_next;

  // Falling-edge effects, computed every cycle and used on a clock-low write
  logic [bsr_pkg::CMD_W-1:0]   fall_shift;
  logic [15:0]                 fall_word;
  logic                        fall_unknown;
  logic                        fall_reply;
  logic [4:0]                  fall_pos;

  bsr_pkg::line_cmd_t          nib;

  assign nib = bsr_pkg::line_cmd_t'(req.write_value[3:0]);

  always_comb begin
    fall_shift   = command_shift;
    fall_word    = reply_word;
    fall_unknown = 1'b0;
    if (bit_position < bsr_pkg::SHIFT_LIMIT) begin
      fall_shift[bit_position[3:0]] = command_shift[bit_position[3:0]] | data_level;
    end
    if (bit_position == bsr_pkg::DECODE_POS) begin
      case (fall_shift)
        bsr_pkg::CMD_VERSION:  fall_word = {bsr_pkg::VERSION_BYTE, req.start_inputs};
        bsr_pkg::CMD_BANK_ONE: fall_word = {banks.switch_bank_one, req.start_inputs};
        bsr_pkg::CMD_BANK_TWO: fall_word = {banks.switch_bank_two, req.start_inputs};
        default:               fall_unknown = 1'b1;
      endcase
    end
    fall_reply = (bit_position < bsr_pkg::REPLY_LIMIT) ? fall_word[bit_position[3:0]] : 1'b0;
    fall_pos   = (bit_position == bsr_pkg::POS_MAX) ? bit_position : bit_position + 5'd1;
  end

  // Next state
  always_comb begin
    reset_held_next    = reset_held;
    bit_position_next  = bit_position;
    command_shift_next = command_shift;
    data_level_next    = data_level;
    clock_level_next   = clock_level;
    reply_bit_next     = reply_bit;
    reply_word_next    = reply_word;
    if (fire && req.action == bsr_pkg::ACT_WRITE) begin
      case (nib)
        bsr_pkg::NIB_RESET_ON: reset_held_next = 1'b1;
        bsr_pkg::NIB_RESET_OFF: begin
          reset_held_next    = 1'b0;
          bit_position_next  = '0;
          command_shift_next = '0;
          data_level_next    = 1'b0;
          reply_bit_next     = 1'b0;
          clock_level_next   = 1'b1;
        end
        bsr_pkg::NIB_DATA_HIGH: data_level_next  = 1'b1;
        bsr_pkg::NIB_DATA_LOW:  data_level_next  = 1'b0;
        bsr_pkg::NIB_CLK_HIGH:  clock_level_next = 1'b1;
        bsr_pkg::NIB_CLK_LOW: begin
          if (clock_level) begin
            command_shift_next = fall_shift;
            reply_word_next    = fall_word;
            reply_bit_next     = fall_reply;
            bit_position_next  = fall_pos;
            clock_level_next   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result of the beat
  always_comb begin
    result = '0;
    if (req.action == bsr_pkg::ACT_READ) begin
      result.read_data[bsr_pkg::READ_CLK_BIT]   = clock_level;
      result.read_data[bsr_pkg::READ_REPLY_BIT] = reply_bit;
    end else if (nib == bsr_pkg::NIB_CLK_LOW && clock_level) begin
      result.unknown_command = fall_unknown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_held    <= 1'b0;
      bit_position  <= '0;
      command_shift <= '0;
      data_level    <= 1'b0;
      clock_level   <= 1'b0;
      reply_bit     <= 1'b0;
      reply_word    <= '0;
    end else begin
      reset_held    <= reset_held_next;
      bit_position  <= bit_position_next;
      command_shift <= command_shift_next;
      data_level    <= data_level_next;
      clock_level   <= clock_level_next;
      reply_bit     <= reply_bit_next;
      reply_word    <= reply_word_next;
    end
  end

`ifndef SYNTHESIS
  a_unknown_only_on_fall: assert property (@(posedge clk) disable iff (rst)
    result.unknown_command |-> (req.action == bsr_pkg::ACT_WRITE) &&
      (nib == bsr_pkg::NIB_CLK_LOW) && clock_level && (bit_position == bsr_pkg::DECODE_POS))
    else $error("unknown command flagged outside a decode edge");

  a_reset_held_set: assert property (@(posedge clk) disable iff (rst)
    fire && (req.action == bsr_pkg::ACT_WRITE) && (nib == bsr_pkg::NIB_RESET_ON) |=> reset_held)
    else $error("reset hold not taken");

  a_reply_zero_past_word: assert property (@(posedge clk) disable iff (rst)
    (bit_position > bsr_pkg::REPLY_LIMIT) |-> !reply_bit)
    else $error("reply bit set beyond the reply word");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // Indexes past the two switch banks; writes there must leave both banks alone
  localparam logic [bsr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [bsr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LIVE_PER_PHASE = 120;
  localparam int PHASES = 5;

  // Line-level copy of the controller: shifter, clock/data lines, reply word,
  // plus the beats it has promised and not yet seen.
  class bitbang_model;
    logic [7:0]      bank_one;
    logic [7:0]      bank_two;
    logic            held;
    logic [4:0]      pos;
    logic [8:0]      cmd_bits;
    logic            data_lv;
    logic            clk_lv;
    logic            reply_bit;
    logic [15:0]     reply_word;
    bsr_pkg::rsp_t   due[$];
    int              mismatches;
    int              strays;
    int              n_reads;
    int              n_edges;
    int              n_known;
    int              n_unknown;

    function void power_on();
      bank_one   = bsr_pkg::BANK_ONE_RESET;
      bank_two   = bsr_pkg::BANK_TWO_RESET;
      held       = 1'b0;
      pos        = '0;
      cmd_bits   = '0;
      data_lv    = 1'b0;
      clk_lv     = 1'b0;
      reply_bit  = 1'b0;
      reply_word = '0;
    endfunction

    function new();
      power_on();
    endfunction

    function void set_bank(logic [bsr_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
      if (idx == bsr_pkg::CFG_BANK_ONE) bank_one = val;
      else if (idx == bsr_pkg::CFG_BANK_TWO) bank_two = val;
    endfunction

    // Falling clock: shift, decode at the last command bit, present a reply bit
    function logic fall(logic [7:0] live);
      logic miss;
      miss = 1'b0;
      if (pos < bsr_pkg::SHIFT_LIMIT) cmd_bits[pos] = cmd_bits[pos] | data_lv;
      if (pos == bsr_pkg::DECODE_POS) begin
        if (cmd_bits == bsr_pkg::CMD_VERSION) reply_word = {bsr_pkg::VERSION_BYTE, live};
        else if (cmd_bits == bsr_pkg::CMD_BANK_ONE) reply_word = {bank_one, live};
        else if (cmd_bits == bsr_pkg::CMD_BANK_TWO) reply_word = {bank_two, live};
        else miss = 1'b1;
        if (miss) n_unknown++;
        else n_known++;
      end
      reply_bit = (pos < bsr_pkg::REPLY_LIMIT) ? reply_word[pos[3:0]] : 1'b0;
      if (pos < bsr_pkg::POS_MAX) pos = pos + 5'd1;
      clk_lv = 1'b0;
      n_edges++;
      return miss;
    endfunction

    function void take_access(bsr_pkg::req_t r);
      bsr_pkg::rsp_t e;
      e = '0;
      if (r.action == bsr_pkg::ACT_READ) begin
        e.read_data[bsr_pkg::READ_CLK_BIT]   = clk_lv;
        e.read_data[bsr_pkg::READ_REPLY_BIT] = reply_bit;
        n_reads++;
      end else begin
        case (r.write_value[3:0])
          bsr_pkg::NIB_RESET_ON: held = 1'b1;
          bsr_pkg::NIB_RESET_OFF: begin
            held      = 1'b0;
            pos       = '0;
            cmd_bits  = '0;
            data_lv   = 1'b0;
            reply_bit = 1'b0;
            clk_lv    = 1'b1;
          end
          bsr_pkg::NIB_DATA_HIGH: data_lv = 1'b1;
          bsr_pkg::NIB_DATA_LOW:  data_lv = 1'b0;
          bsr_pkg::NIB_CLK_HIGH:  clk_lv = 1'b1;
          bsr_pkg::NIB_CLK_LOW: begin
            if (clk_lv) e.unknown_command = fall(r.start_inputs);
          end
          default: ;
        endcase
      end
      due.push_back(e);
    endfunction

    function void report(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches + strays <= 10)
        $display("mismatch on %s: expected %02h, got %02h", what, want, got);
    endfunction

    function void match_result(bsr_pkg::rsp_t got);
      bsr_pkg::rsp_t e;
      if (due.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("result beat %h arrived with nothing outstanding", got);
        return;
      end
      e = due.pop_front();
      if (got.read_data !== e.read_data) report("read_data", e.read_data, got.read_data);
      if (got.unknown_command !== e.unknown_command)
        report("unknown_command", {7'b0, e.unknown_command}, {7'b0, got.unknown_command});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bsr_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bsr_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [bsr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  bitbang_model model = new();
  bit calm = 1'b0;          // while set, neither side idles
  int live_items = 0;       // accesses the block acts on (ignored nibbles excluded)
  int cfg_writes = 0;
  int cycle_count = 0;
  int stall_left = 0;

  bitbang_serial_command_responder uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Mostly back to back, sometimes a short pause, now and then a long one
  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic bsr_pkg::req_t access(logic a, logic [7:0] w, logic [7:0] s);
    bsr_pkg::req_t r;
    r.action       = a;
    r.write_value  = w;
    r.start_inputs = s;
    return r;
  endfunction

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d beats outstanding",
               cycle_count, model.due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check every accepted beat, then decide whether to hold off
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) model.match_result(rsp);
    if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_idle();
    end
  end

  // Present one request beat and hold it until the block takes it.
  // With no gap, only the payload changes so valid stays high across beats.
  task automatic send_access(bsr_pkg::req_t item);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    model.take_access(item);
    if (item.action == bsr_pkg::ACT_READ || item.write_value[3:0] inside {
        bsr_pkg::NIB_RESET_ON, bsr_pkg::NIB_RESET_OFF, bsr_pkg::NIB_DATA_HIGH,
        bsr_pkg::NIB_DATA_LOW, bsr_pkg::NIB_CLK_HIGH, bsr_pkg::NIB_CLK_LOW})
      live_items++;
  endtask

  // Line command with random junk in the undecoded high nibble
  task automatic put_line(bsr_pkg::line_cmd_t nib);
    send_access(access(bsr_pkg::ACT_WRITE, {4'($urandom_range(0, 15)), nib}, 8'($urandom)));
  endtask

  task automatic peek();
    send_access(access(bsr_pkg::ACT_READ, 8'($urandom), 8'($urandom)));
  endtask

  task automatic noise();
    send_access(bsr_pkg::req_t'($bits(bsr_pkg::req_t)'($urandom)));
  endtask

  // Full transfer: release reset, clock in nine command bits LSB first,
  // then keep clocking to shift the reply out. Sprinkle stray accesses in.
  task automatic send_command(logic [8:0] code, int tail);
    put_line(bsr_pkg::NIB_RESET_OFF);
    for (int i = 0; i < 9; i++) begin
      put_line(code[i] ? bsr_pkg::NIB_DATA_HIGH : bsr_pkg::NIB_DATA_LOW);
      put_line(bsr_pkg::NIB_CLK_LOW);
      if ($urandom_range(0, 2) == 0) peek();
      if ($urandom_range(0, 11) == 0) noise();
      put_line(bsr_pkg::NIB_CLK_HIGH);
    end
    for (int t = 0; t < tail; t++) begin
      put_line(bsr_pkg::NIB_CLK_LOW);
      peek();
      if ($urandom_range(0, 15) == 0) noise();
      put_line(bsr_pkg::NIB_CLK_HIGH);
      if ($urandom_range(0, 1) == 0) peek();
    end
  endtask

  function automatic logic [8:0] pick_code();
    logic [8:0] known;
    case ($urandom_range(0, 2))
      0: known = bsr_pkg::CMD_VERSION;
      1: known = bsr_pkg::CMD_BANK_ONE;
      default: known = bsr_pkg::CMD_BANK_TWO;
    endcase
    case ($urandom_range(0, 9))
      0, 1: return 9'($urandom);
      2: return known ^ (9'd1 << $urandom_range(0, 8));
      default: return known;
    endcase
  endfunction

  function automatic int pick_tail();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(7, 9);
    if (r < 9) return $urandom_range(0, 6);
    return $urandom_range(22, 28);   // run the position into saturation
  endfunction

  // Drain: drop valid, wait for every promised beat back, then let the result register empty
  task automatic wait_quiet();
    req_valid <= 1'b0;
    while (model.due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(logic [bsr_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    model.set_bank(idx, val);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int fails;
    logic [7:0] one_val;
    logic [7:0] two_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset state, ignored nibbles, redundant clock moves,
    // reset held and released, edges with the data line both ways
    send_access(access(bsr_pkg::ACT_READ,  8'h00, 8'h00));
    send_access(access(bsr_pkg::ACT_READ,  8'hFF, 8'hFF));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h0E, 8'h00));   // lower while already low
    send_access(access(bsr_pkg::ACT_WRITE, 8'h00, 8'hFF));
    send_access(access(bsr_pkg::ACT_WRITE, 8'hA7, 8'h5A));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h5A, 8'hA5));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h0B, 8'h3C));
    send_access(access(bsr_pkg::ACT_WRITE, 8'hF9, 8'h00));   // reset held, gates nothing
    send_access(access(bsr_pkg::ACT_WRITE, 8'h0D, 8'h00));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h7F, 8'h00));
    send_access(access(bsr_pkg::ACT_WRITE, 8'hFF, 8'h00));   // raise while already high
    send_access(access(bsr_pkg::ACT_READ,  8'h00, 8'h00));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h1E, 8'hFF));
    send_access(access(bsr_pkg::ACT_READ,  8'h00, 8'h00));
    send_access(access(bsr_pkg::ACT_WRITE, 8'hEE, 8'hFF));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h39, 8'h00));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h88, 8'h00));   // release: clock comes up high
    send_access(access(bsr_pkg::ACT_READ,  8'h00, 8'h00));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h6C, 8'h00));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h0E, 8'h00));
    send_access(access(bsr_pkg::ACT_READ,  8'hFF, 8'h00));
    send_access(access(bsr_pkg::ACT_WRITE, 8'h0F, 8'h00));
    send_access(access(bsr_pkg::ACT_READ,  8'h55, 8'hAA));

    // Random: phase 0 runs on the reset banks, later phases reprogram them
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_quiet();
        case (p)
          1: begin
            one_val = 8'h00;
            two_val = 8'hFF;
          end
          2: begin
            one_val = 8'hFF;
            two_val = 8'h00;
          end
          default: begin
            one_val = 8'($urandom);
            two_val = 8'($urandom);
          end
        endcase
        write_cfg(bsr_pkg::CFG_BANK_ONE, one_val);
        write_cfg(bsr_pkg::CFG_BANK_TWO, two_val);
        write_cfg(2'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 8'($urandom));
      end
      while (live_items < LIVE_PER_PHASE * (p + 1)) begin
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) noise();
        end else begin
          send_command(pick_code(), pick_tail());
        end
      end
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    wait_quiet();
    repeat (4) @(posedge clk);

    fails = model.mismatches + model.strays + model.due.size();
    $display("covered %0d live accesses: %0d reads, %0d falling edges,",
             live_items, model.n_reads, model.n_edges);
    $display("%0d known and %0d unknown commands; banks written %0d times over %0d settings",
             model.n_known, model.n_unknown, cfg_writes, PHASES);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bsr_pkg.sv
hw/rtl/bsr_cfg.sv
hw/rtl/bsr_core.sv
hw/rtl/bitbang_serial_command_responder.sv
dv/tb.sv
